// ----- hdl/fnc_pkg.sv -----
// ----------------------------------------------------------------------------
// fnc_pkg
// Types, constants and the elaboration-time log2 helper of the note tuner.
// ----------------------------------------------------------------------------
package fnc_pkg;

  localparam int FREQ_W    = 24;
  localparam int LOG_FRAC  = 24;
  localparam int MANT_BITS = 30;
  localparam int P_W       = 5;
  localparam int M_W       = MANT_BITS + 1;
  localparam int LOG_W     = P_W + LOG_FRAC;

  localparam int FREQ_LO_HZ = 27;
  localparam int FREQ_HI_HZ = 24000;

  localparam int CM_W = 17;
  localparam int X_W  = 14;
  localparam int Q_W  = 10;
  localparam int S_W  = 7;
  localparam int OCT_W = 4;
  localparam int NOTE_W = 4;
  localparam int DEV_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [10:0]     CENTS_MUL  = 11'd1200;
  localparam logic [CM_W-1:0] CENTS_MIN  = CM_W'(44);
  localparam logic [CM_W-1:0] CENTS_MAX  = CM_W'(8754);
  localparam logic [CM_W-1:0] ROUND_HALF = CM_W'(5);

  localparam logic [15:0] RECIP10    = 16'd52429;
  localparam int          RECIP10_SH = 19;
  localparam logic [5:0]  RECIP12    = 6'd43;
  localparam int          RECIP12_SH = 9;
  localparam logic [Q_W:0] SNAP_BIAS = (Q_W+1)'(4);
  localparam logic [NOTE_W-1:0] NOTE_C = NOTE_W'(3);

  // bit i set for the black keys, A at bit 0
  localparam logic [11:0] SHARP_MASK = 12'b1010_0101_0010;

  localparam logic [STAT_W-1:0] ST_RANGE = 2'd0;
  localparam logic [STAT_W-1:0] ST_BELOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABOVE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTE  = 2'd3;

  typedef struct packed {
    logic             inr;
    logic [LOG_W-1:0] lg;
  } fnc_log_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              neg;
    logic [X_W-1:0]    x;
  } fnc_cents_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [NOTE_W-1:0]       note_index;
    logic                    is_sharp;
    logic [OCT_W-1:0]        octave;
    logic signed [DEV_W-1:0] deviation;
  } fnc_res_t;

  // same squaring log2 as the datapath, evaluated at elaboration only
  function automatic logic [LOG_W-1:0] fnc_log2_const(input logic [31:0] x);
    logic [63:0]         m;
    logic [LOG_FRAC-1:0] frac;
    logic [P_W-1:0]      p;
    p    = '0;
    frac = '0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) begin
        p = P_W'(i);
      end
    end
    m = 64'(x) << (P_W'(MANT_BITS) - p);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m    = (m * m) >> MANT_BITS;
      frac = {frac[LOG_FRAC-2:0], 1'b0};
      if (m >= (64'd2 << MANT_BITS)) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {p, frac};
  endfunction

  localparam logic [LOG_W-1:0] LOG2_55 = fnc_log2_const(32'd55);

endpackage

// ----- hdl/fnc_in_if.sv -----
// ----------------------------------------------------------------------------
// fnc_in_if
// Frequency channel: valid, ready and one fixed-point frequency.
// ----------------------------------------------------------------------------
interface fnc_in_if import fnc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;

  modport source (output valid, output frequency, input ready);
  modport sink   (input valid, input frequency, output ready);
endinterface

// ----- hdl/fnc_out_if.sv -----
// ----------------------------------------------------------------------------
// fnc_out_if
// Tuner reading channel: valid, ready, status, note, octave and deviation.
// ----------------------------------------------------------------------------
interface fnc_out_if import fnc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [NOTE_W-1:0]       note_index;
  logic                    is_sharp;
  logic [OCT_W-1:0]        octave;
  logic signed [DEV_W-1:0] deviation;

  modport source (output valid, output status, output note_index, output is_sharp,
                  output octave, output deviation, input ready);
  modport sink   (input valid, input status, input note_index, input is_sharp,
                  input octave, input deviation, output ready);
endinterface

// ----- hdl/fnc_log2.sv -----
// ----------------------------------------------------------------------------
// fnc_log2
// Range check, normalization and a 24-stage squaring log2 pipeline.
// ----------------------------------------------------------------------------
module fnc_log2 import fnc_pkg::*; #(
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [FREQ_W-1:0] in_freq,
  output logic              out_vld,
  output fnc_log_t          out_log
);

  localparam int CMP_W = FREQ_W + 16;
  localparam logic [CMP_W-1:0] F_LO = CMP_W'(FREQ_LO_HZ) << FREQ_FRAC_BITS;
  localparam logic [CMP_W-1:0] F_HI = CMP_W'(FREQ_HI_HZ) << FREQ_FRAC_BITS;

  // stage a: top bit search and range check
  logic              a_vld_r;
  logic [FREQ_W-1:0] a_f_r;
  logic [P_W-1:0]    a_p_r, a_p_nxt;
  logic              a_inr_r, a_inr_nxt;

  // stage b: mantissa normalized to q30
  logic              b_vld_r;
  logic [M_W-1:0]    b_m_r, b_m_nxt;
  logic [P_W-1:0]    b_p_r;
  logic              b_inr_r;

  // squaring stages, one fraction bit each
  logic [LOG_FRAC-1:0] c_vld_r, c_vld_nxt;
  logic [M_W-1:0]      c_m_r    [LOG_FRAC];
  logic [M_W-1:0]      c_m_nxt  [LOG_FRAC];
  logic [LOG_FRAC-1:0] c_frac_r [LOG_FRAC];
  logic [LOG_FRAC-1:0] c_frac_nxt [LOG_FRAC];
  logic [P_W-1:0]      c_p_r    [LOG_FRAC];
  logic [P_W-1:0]      c_p_nxt  [LOG_FRAC];
  logic [LOG_FRAC-1:0] c_inr_r, c_inr_nxt;

  always_comb begin
    a_p_nxt = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (in_freq[i]) begin
        a_p_nxt = P_W'(i);
      end
    end
    a_inr_nxt = (CMP_W'(in_freq) >= F_LO) && (CMP_W'(in_freq) <= F_HI);
  end

  assign b_m_nxt = M_W'(a_f_r) << (P_W'(MANT_BITS) - a_p_r);

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic [M_W-1:0]      sq_m;
    logic [LOG_FRAC-1:0] sq_frac;
    logic [2*M_W-1:0]    sq;
    logic [M_W:0]        sq_top;

    if (g == 0) begin : g_first
      assign sq_m         = b_m_r;
      assign sq_frac      = '0;
      assign c_p_nxt[g]   = b_p_r;
      assign c_inr_nxt[g] = b_inr_r;
      assign c_vld_nxt[g] = b_vld_r;
    end else begin : g_rest
      assign sq_m         = c_m_r[g-1];
      assign sq_frac      = c_frac_r[g-1];
      assign c_p_nxt[g]   = c_p_r[g-1];
      assign c_inr_nxt[g] = c_inr_r[g-1];
      assign c_vld_nxt[g] = c_vld_r[g-1];
    end

    assign sq     = sq_m * sq_m;
    assign sq_top = sq[2*M_W-1:MANT_BITS];
    // square reached 2.0: emit a one and halve
    assign c_m_nxt[g]    = sq_top[M_W] ? sq_top[M_W:1] : sq_top[M_W-1:0];
    assign c_frac_nxt[g] = {sq_frac[LOG_FRAC-2:0], sq_top[M_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= '0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= c_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f_r   <= in_freq;
      a_p_r   <= a_p_nxt;
      a_inr_r <= a_inr_nxt;
      b_m_r   <= b_m_nxt;
      b_p_r   <= a_p_r;
      b_inr_r <= a_inr_r;
      c_inr_r <= c_inr_nxt;
      for (int i = 0; i < LOG_FRAC; i++) begin
        c_m_r[i]    <= c_m_nxt[i];
        c_frac_r[i] <= c_frac_nxt[i];
        c_p_r[i]    <= c_p_nxt[i];
      end
    end
  end

  assign out_vld     = c_vld_r[LOG_FRAC-1];
  assign out_log.inr = c_inr_r[LOG_FRAC-1];
  assign out_log.lg  = {c_p_r[LOG_FRAC-1], c_frac_r[LOG_FRAC-1]};

endmodule

// ----- hdl/fnc_cents.sv -----
// ----------------------------------------------------------------------------
// fnc_cents
// Log difference to A0, scale to cents and classify the reading.
// ----------------------------------------------------------------------------
module fnc_cents import fnc_pkg::*; #(
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  fnc_log_t   in_log,
  output logic       out_vld,
  output fnc_cents_t out_cents
);

  localparam int D_W    = LOG_W + 2;
  localparam int MAG_W  = D_W - 1;
  localparam int PROD_W = MAG_W + 11;
  // log2 of 27.5 plus the input scaling, in log units
  localparam logic [D_W-1:0] LOG_OFS = (D_W'(FREQ_FRAC_BITS) << LOG_FRAC)
                                     + D_W'(LOG2_55) - (D_W'(1) << LOG_FRAC);

  logic              d_vld_r;
  logic              d_neg_r, d_neg_nxt;
  logic [MAG_W-1:0]  d_mag_r, d_mag_nxt;
  logic              d_inr_r;
  logic [D_W-1:0]    diff, diff_neg;

  logic              e_vld_r;
  logic              e_neg_r;
  logic              e_inr_r;
  logic [PROD_W-1:0] e_prod_r, e_prod_nxt;

  logic              f_vld_r;
  fnc_cents_t        f_cents_r, f_cents_nxt;
  logic [CM_W-1:0]   cmag;

  always_comb begin
    diff      = D_W'(in_log.lg) - LOG_OFS;
    diff_neg  = -diff;
    d_neg_nxt = diff[D_W-1];
    d_mag_nxt = d_neg_nxt ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
  end

  assign e_prod_nxt = PROD_W'(d_mag_r) * PROD_W'(CENTS_MUL);

  always_comb begin
    cmag            = e_prod_r[PROD_W-1:LOG_FRAC];
    f_cents_nxt.neg = e_neg_r;
    // negative readings truncate, positive ones round half up
    f_cents_nxt.x   = e_neg_r ? cmag[X_W-1:0] : X_W'(cmag + ROUND_HALF);
    if (!e_inr_r) begin
      f_cents_nxt.status = ST_RANGE;
    end else if (e_neg_r && (cmag > CENTS_MIN)) begin
      f_cents_nxt.status = ST_BELOW;
    end else if (!e_neg_r && (cmag > CENTS_MAX)) begin
      f_cents_nxt.status = ST_ABOVE;
    end else begin
      f_cents_nxt.status = ST_NOTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= in_vld;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg_r   <= d_neg_nxt;
      d_mag_r   <= d_mag_nxt;
      d_inr_r   <= in_log.inr;
      e_neg_r   <= d_neg_r;
      e_inr_r   <= d_inr_r;
      e_prod_r  <= e_prod_nxt;
      f_cents_r <= f_cents_nxt;
    end
  end

  assign out_vld   = f_vld_r;
  assign out_cents = f_cents_r;

endmodule

// ----- hdl/fnc_note.sv -----
// ----------------------------------------------------------------------------
// fnc_note
// Tens of cents, semitone snap and split into note, octave and deviation.
// ----------------------------------------------------------------------------
module fnc_note import fnc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  fnc_cents_t in_cents,
  output logic       out_vld,
  output fnc_res_t   out_res
);

  localparam int G_PW = X_W + 16;
  localparam int H_PW = Q_W + 1 + 16;
  localparam int J_PW = S_W + 6;

  // g: tens of cents
  logic              g_vld_r;
  logic [STAT_W-1:0] g_status_r;
  logic              g_neg_r;
  logic [Q_W-1:0]    g_q_r, g_q_nxt;

  // h: semitone count
  logic              h_vld_r;
  logic [STAT_W-1:0] h_status_r;
  logic              h_neg_r;
  logic [Q_W-1:0]    h_q_r;
  logic [S_W-1:0]    h_semis_r, h_semis_nxt;
  logic [Q_W:0]      h_y;

  // i: deviation from the semitone
  logic              i_vld_r;
  logic [STAT_W-1:0] i_status_r;
  logic [S_W-1:0]    i_semis_r, i_semis_nxt;
  logic [DEV_W-1:0]  i_dev_r, i_dev_nxt;
  logic [Q_W:0]      i_ten_s, i_diff;

  // j: semitones per octave
  logic              j_vld_r;
  logic [STAT_W-1:0] j_status_r;
  logic [S_W-1:0]    j_semis_r;
  logic [DEV_W-1:0]  j_dev_r;
  logic [OCT_W-1:0]  j_q12_r, j_q12_nxt;

  // k: result
  logic              k_vld_r;
  fnc_res_t          k_res_r, k_res_nxt;
  logic [S_W-1:0]    k_rem;
  logic [NOTE_W-1:0] k_note;

  assign g_q_nxt = Q_W'((G_PW'(in_cents.x) * G_PW'(RECIP10)) >> RECIP10_SH);

  always_comb begin
    h_y         = (Q_W+1)'(g_q_r) + SNAP_BIAS;
    h_semis_nxt = S_W'((H_PW'(h_y) * H_PW'(RECIP10)) >> RECIP10_SH);
  end

  always_comb begin
    i_ten_s = ((Q_W+1)'(h_semis_r) << 3) + ((Q_W+1)'(h_semis_r) << 1);
    i_diff  = (Q_W+1)'(h_q_r) - i_ten_s;
    // below A0 the reading snaps to A0 itself
    if (h_neg_r) begin
      i_semis_nxt = '0;
      i_dev_nxt   = DEV_W'(-(Q_W+1)'(h_q_r));
    end else begin
      i_semis_nxt = h_semis_r;
      i_dev_nxt   = i_diff[DEV_W-1:0];
    end
  end

  assign j_q12_nxt = OCT_W'((J_PW'(i_semis_r) * J_PW'(RECIP12)) >> RECIP12_SH);

  always_comb begin
    k_rem  = j_semis_r - ((S_W'(j_q12_r) << 3) + (S_W'(j_q12_r) << 2));
    k_note = k_rem[NOTE_W-1:0];
    k_res_nxt.status = j_status_r;
    if (j_status_r == ST_NOTE) begin
      k_res_nxt.note_index = k_note;
      k_res_nxt.is_sharp   = SHARP_MASK[k_note];
      // octave number steps up at C
      k_res_nxt.octave     = j_q12_r + OCT_W'(k_note >= NOTE_C);
      k_res_nxt.deviation  = j_dev_r;
    end else begin
      k_res_nxt.note_index = '0;
      k_res_nxt.is_sharp   = 1'b0;
      k_res_nxt.octave     = '0;
      k_res_nxt.deviation  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= in_vld;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_status_r <= in_cents.status;
      g_neg_r    <= in_cents.neg;
      g_q_r      <= g_q_nxt;
      h_status_r <= g_status_r;
      h_neg_r    <= g_neg_r;
      h_q_r      <= g_q_r;
      h_semis_r  <= h_semis_nxt;
      i_status_r <= h_status_r;
      i_semis_r  <= i_semis_nxt;
      i_dev_r    <= i_dev_nxt;
      j_status_r <= i_status_r;
      j_semis_r  <= i_semis_r;
      j_dev_r    <= i_dev_r;
      j_q12_r    <= j_q12_nxt;
      k_res_r    <= k_res_nxt;
    end
  end

  assign out_vld = k_vld_r;
  assign out_res = k_res_r;

endmodule

// ----- hdl/frequency_to_note_cents.sv -----
// ----------------------------------------------------------------------------
// frequency_to_note_cents
// Tuner reading (note, octave, deviation in tens of cents) from a frequency.
// ----------------------------------------------------------------------------
// The block takes one frequency per cycle while in_ch.ready is high and
// returns one reading per frequency, in order. Most of the pipeline depth
// lies in the log2, which spends one pipeline stage per fraction bit (24
// squaring stages of a 31x31 multiplier); normalization, scaling to cents,
// rounding and the note split add ten more stages. The whole
// pipeline moves as one; a one-entry skid register at the output takes the
// last result when the sink stalls, so in_ch.ready comes from a flop and goes
// low only while that register is full.
module frequency_to_note_cents import fnc_pkg::*; #(
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  fnc_in_if.sink    in_ch,
  fnc_out_if.source out_ch
);

  logic       pipe_en;
  logic       log_vld;
  fnc_log_t   log_res;
  logic       cents_vld;
  fnc_cents_t cents_res;
  logic       note_vld;
  fnc_res_t   note_res;

  logic       skid_vld_r, skid_vld_nxt;
  fnc_res_t   skid_r;
  fnc_res_t   out_res;

  assign pipe_en     = !skid_vld_r;
  assign in_ch.ready = pipe_en;

  fnc_log2 #(
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (in_ch.valid),
    .in_freq (in_ch.frequency),
    .out_vld (log_vld),
    .out_log (log_res)
  );

  fnc_cents #(
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_cents (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_vld    (log_vld),
    .in_log    (log_res),
    .out_vld   (cents_vld),
    .out_cents (cents_res)
  );

  fnc_note u_note (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (cents_vld),
    .in_cents (cents_res),
    .out_vld  (note_vld),
    .out_res  (note_res)
  );

  // skid holds the older result, so it goes out first
  always_comb begin
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_ch.ready) begin
        skid_vld_nxt = 1'b0;
      end
    end else if (note_vld && !out_ch.ready) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_r <= note_res;
    end
  end

  assign out_res           = skid_vld_r ? skid_r : note_res;
  assign out_ch.valid      = skid_vld_r || note_vld;
  assign out_ch.status     = out_res.status;
  assign out_ch.note_index = out_res.note_index;
  assign out_ch.is_sharp   = out_res.is_sharp;
  assign out_ch.octave     = out_res.octave;
  assign out_ch.deviation  = out_res.deviation;

`ifndef SYNTHESIS
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_ch.ready |=> skid_vld_r && $stable(skid_r))
    else $error("skid entry changed while stalled");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_vld_r && note_vld && !out_ch.ready |=> skid_vld_r && !in_ch.ready)
    else $error("stalled result not captured");

  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_NOTE) |->
      (out_ch.note_index < 4'd12) && (out_ch.octave <= 4'd8) &&
      (out_ch.deviation >= -4) && (out_ch.deviation <= 5) &&
      (out_ch.is_sharp == SHARP_MASK[out_ch.note_index]))
    else $error("note reading out of range");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_NOTE) |->
      (out_ch.note_index == '0) && !out_ch.is_sharp &&
      (out_ch.octave == '0) && (out_ch.deviation == '0))
    else $error("fields set without a note");
`endif

endmodule
